// ===== rtl/linked_list_reorder_engine_top_defines.svh =====
// assertion macros for the linked-list reorder engine
// used by modules that check their own control logic; expects clk and arst_n in scope
`ifndef LINKED_LIST_REORDER_ENGINE_TOP_DEFINES_SVH
`define LINKED_LIST_REORDER_ENGINE_TOP_DEFINES_SVH

// implication or sequence property, checked out of reset
`define LLRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// plain condition that must hold on every clock edge out of reset
`define LLRE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== rtl/llre_pkg.sv =====
// shared constants, command codes and types of the linked-list reorder engine
// no dependencies
`timescale 1ns / 1ps

package llre_pkg;

	localparam int MAX_ITEMS   = 1024;
	localparam int NODES       = MAX_ITEMS + 1;
	localparam int IDX_W       = $clog2(NODES);
	localparam int LEN_W       = 11;
	localparam int MODE_W      = 3;
	localparam int SUM_W       = 20;
	localparam int JOIN_SLOTS  = 4;
	localparam int JCNT_W      = $clog2(JOIN_SLOTS + 1);
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MOVE_L = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MOVE_R = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SWAP   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REV    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_REPORT = 3'd5;

	// one port of a link memory as driven by the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} link_port_t;

	// right_link[a] = b and left_link[b] = a
	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
	} join_t;

endpackage

// ===== rtl/llre_link_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module llre_link_ram #(
	parameter int DEPTH = 1025,
	parameter int WIDTH = 11,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/llre_seq.sv =====
// command sequencer: reads the link memories, plans the relinks and writes them back
// depends on llre_pkg and linked_list_reorder_engine_top_defines.svh
`timescale 1ns / 1ps
`include "linked_list_reorder_engine_top_defines.svh"

module llre_seq import llre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0]  item_x,
	input  logic [IDX_W-1:0]  item_y,
	input  logic [LEN_W-1:0]  list_length,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [SUM_W-1:0]  res_sum,
	output link_port_t        rport,
	output link_port_t        lport,
	input  logic [IDX_W-1:0]  r_rdata,
	input  logic [IDX_W-1:0]  l_rdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_WALK0 = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_RDY   = 3'd5;
	localparam logic [2:0] ST_PLAN  = 3'd6;
	localparam logic [2:0] ST_WRITE = 3'd7;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  n_q;
	logic              rev_q;
	logic [SUM_W-1:0]  tri_q;
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [MODE_W-1:0] op_q;
	logic [IDX_W-1:0]  x_q;
	logic [IDX_W-1:0]  y_q;
	logic [IDX_W-1:0]  lx_q;
	logic [IDX_W-1:0]  rx_q;
	join_t             joins_q [JOIN_SLOTS];
	logic [JCNT_W-1:0] jcnt_q;

	logic              accept;
	logic [IDX_W-1:0]  n_sat;
	logic [IDX_W:0]    n_p1;
	logic [2*IDX_W:0]  tri_prod;
	logic              cmd_ok;
	logic [MODE_W-1:0] eff_mode;

	// relink plan
	join_t             plan [JOIN_SLOTS];
	logic [JCNT_W-1:0] plan_cnt;
	logic              sw;
	logic [IDX_W-1:0]  ax, ay, alx, arx, aly, ary;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		if (list_length == '0) begin
			n_sat = IDX_W'(1);
		end else if (list_length > LEN_W'(MAX_ITEMS)) begin
			n_sat = IDX_W'(MAX_ITEMS);
		end else begin
			n_sat = IDX_W'(list_length);
		end
	end

	assign n_p1     = {1'b0, n_sat} + (IDX_W + 1)'(1);
	assign tri_prod = (2 * IDX_W + 1)'(n_sat) * (2 * IDX_W + 1)'(n_p1);

	assign cmd_ok = (item_x != item_y) && (item_x != '0) && (item_y != '0) &&
		(item_x <= n_q) && (item_y <= n_q);

	// left and right moves trade places while the list is reversed
	always_comb begin
		eff_mode = mode;
		if (rev_q && mode == MODE_MOVE_L) begin
			eff_mode = MODE_MOVE_R;
		end else if (rev_q && mode == MODE_MOVE_R) begin
			eff_mode = MODE_MOVE_L;
		end
	end

	// in PLAN the read data holds left and right of y
	always_comb begin
		sw  = (r_rdata == x_q);
		ax  = sw ? y_q : x_q;
		ay  = sw ? x_q : y_q;
		alx = sw ? l_rdata : lx_q;
		arx = sw ? r_rdata : rx_q;
		aly = sw ? lx_q : l_rdata;
		ary = sw ? rx_q : r_rdata;
		for (int i = 0; i < JOIN_SLOTS; i++) begin
			plan[i] = '0;
		end
		plan_cnt = '0;
		unique case (op_q)
			MODE_MOVE_L: begin
				if (x_q != l_rdata) begin
					plan[0]  = '{a: lx_q, b: rx_q};
					plan[1]  = '{a: l_rdata, b: x_q};
					plan[2]  = '{a: x_q, b: y_q};
					plan_cnt = JCNT_W'(3);
				end
			end
			MODE_MOVE_R: begin
				if (x_q != r_rdata) begin
					plan[0]  = '{a: lx_q, b: rx_q};
					plan[1]  = '{a: y_q, b: x_q};
					plan[2]  = '{a: x_q, b: r_rdata};
					plan_cnt = JCNT_W'(3);
				end
			end
			default: begin
				plan[0] = '{a: alx, b: ay};
				if (arx == ay) begin
					plan[1]  = '{a: ay, b: ax};
					plan[2]  = '{a: ax, b: ary};
					plan_cnt = JCNT_W'(3);
				end else begin
					plan[1]  = '{a: ay, b: arx};
					plan[2]  = '{a: aly, b: ax};
					plan[3]  = '{a: ax, b: ary};
					plan_cnt = JCNT_W'(4);
				end
			end
		endcase
	end

	// memory ports
	always_comb begin
		rport = '0;
		lport = '0;
		unique case (state_q)
			ST_IDLE: begin
				rport.raddr = item_x;
			end
			ST_RDY: begin
				rport.raddr = y_q;
			end
			ST_WALK: begin
				rport.raddr = r_rdata;
			end
			ST_INIT: begin
				rport.we    = 1'b1;
				rport.waddr = cnt_q;
				rport.wdata = (cnt_q == n_q) ? '0 : cnt_q + IDX_W'(1);
				lport.we    = 1'b1;
				lport.waddr = cnt_q;
				lport.wdata = (cnt_q == '0) ? n_q : cnt_q - IDX_W'(1);
			end
			ST_WRITE: begin
				rport.we    = 1'b1;
				rport.waddr = joins_q[0].a;
				rport.wdata = joins_q[0].b;
				lport.we    = 1'b1;
				lport.waddr = joins_q[0].b;
				lport.wdata = joins_q[0].a;
			end
			default: begin
			end
		endcase
		lport.raddr = rport.raddr;
	end

	assign res_valid = (state_q == ST_FIN);
	assign res_sum   = (rev_q && !n_q[0]) ? tri_q - sum_q : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			rev_q   <= 1'b0;
			tri_q   <= '0;
			jcnt_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode) inside
							MODE_INIT: begin
								n_q     <= n_sat;
								tri_q   <= SUM_W'(tri_prod >> 1);
								rev_q   <= 1'b0;
								cnt_q   <= '0;
								state_q <= ST_INIT;
							end
							MODE_REV: begin
								rev_q <= !rev_q;
							end
							MODE_REPORT: begin
								cnt_q   <= IDX_W'(1);
								state_q <= (n_q == '0) ? ST_FIN : ST_WALK0;
							end
							MODE_MOVE_L, MODE_MOVE_R, MODE_SWAP: begin
								if (cmd_ok) begin
									state_q <= ST_RDY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == n_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK0: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == n_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDY: begin
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					jcnt_q  <= plan_cnt;
					state_q <= (plan_cnt == '0) ? ST_IDLE : ST_WRITE;
				end
				ST_WRITE: begin
					jcnt_q <= jcnt_q - JCNT_W'(1);
					if (jcnt_q == JCNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			op_q  <= eff_mode;
			x_q   <= item_x;
			y_q   <= item_y;
			sum_q <= '0;
		end
		if (state_q == ST_RDY) begin
			lx_q <= l_rdata;
			rx_q <= r_rdata;
		end
		if (state_q == ST_WALK && cnt_q[0]) begin
			sum_q <= sum_q + SUM_W'(r_rdata);
		end
		if (state_q == ST_PLAN) begin
			for (int i = 0; i < JOIN_SLOTS; i++) begin
				joins_q[i] <= plan[i];
			end
		end else if (state_q == ST_WRITE) begin
			for (int i = 0; i < JOIN_SLOTS - 1; i++) begin
				joins_q[i] <= joins_q[i + 1];
			end
			joins_q[JOIN_SLOTS - 1] <= '0;
		end
	end

	`LLRE_ASSERT_ALWAYS(a_n_range, n_q <= IDX_W'(MAX_ITEMS), "active count beyond capacity")
	`LLRE_ASSERT(a_walk_range, (state_q == ST_WALK) |-> (cnt_q != '0 && cnt_q <= n_q), "walk index out of list")
	`LLRE_ASSERT(a_write_count, (state_q == ST_WRITE) |-> (jcnt_q != '0 && jcnt_q <= JCNT_W'(JOIN_SLOTS)), "bad relink count")
	`LLRE_ASSERT(a_rev_toggle, (accept && mode == MODE_REV) |=> (rev_q != $past(rev_q)), "reverse request did not toggle")

endmodule

// ===== rtl/linked_list_reorder_engine_top.sv =====
// Linked-list reorder engine.
// s_axis carries one command request per beat: mode, item_x, item_y. The list is held
// as right and left links in two 1025-entry rams, node 0 being the sentinel.
// m_axis carries one result, the odd-position sum, for each report request only.
// cfg_valid/cfg_ready/cfg_data write list_length, used by the next init; write it idle.
// Handling of each request, from s_axis accept to the next s_axis_tready:
//   reverse, out-of-range, equal-item and unused modes: taken without leaving idle
//   move or swap: reads of x and then y, then 3 or 4 relink writes;
//   a move already in place writes nothing
//   init: one entry of each ram per cycle, nodes 0 to N; report: a walk, skipped on an empty list;
//   the walk follows one right link per cycle through the read latency of the right ram
// The report result lands in an output register; the next request is taken while it
// waits. A second report holds in its final cycle until the register frees up.
// Reset clears the reversal flag and empties the list (moves ignored, report gives 0);
// link contents are undefined until an init. list_length resets to 1024.
// depends on llre_pkg, llre_seq, llre_link_ram
`timescale 1ns / 1ps

module linked_list_reorder_engine_top import llre_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[2:0], item_x[13:3], item_y[24:14]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // odd_position_sum[19:0]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data
);

	logic [LEN_W-1:0] len_q;
	logic             out_v_q;
	logic [SUM_W-1:0] out_d_q;

	logic             res_valid;
	logic             res_ready;
	logic [SUM_W-1:0] res_sum;
	link_port_t       rport;
	link_port_t       lport;
	logic [IDX_W-1:0] r_rdata;
	logic [IDX_W-1:0] l_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(MAX_ITEMS);
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	assign res_ready = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_ready) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_d_q <= res_sum;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - SUM_W)'(0), out_d_q};

	llre_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.mode       (s_axis_tdata[MODE_W-1:0]),
		.item_x     (s_axis_tdata[MODE_W+IDX_W-1:MODE_W]),
		.item_y     (s_axis_tdata[MODE_W+2*IDX_W-1:MODE_W+IDX_W]),
		.list_length(len_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_sum    (res_sum),
		.rport      (rport),
		.lport      (lport),
		.r_rdata    (r_rdata),
		.l_rdata    (l_rdata)
	);

	llre_link_ram #(
		.DEPTH(NODES),
		.WIDTH(IDX_W)
	) u_right_ram (
		.clk  (clk),
		.we   (rport.we),
		.waddr(rport.waddr),
		.wdata(rport.wdata),
		.raddr(rport.raddr),
		.rdata(r_rdata)
	);

	llre_link_ram #(
		.DEPTH(NODES),
		.WIDTH(IDX_W)
	) u_left_ram (
		.clk  (clk),
		.we   (lport.we),
		.waddr(lport.waddr),
		.wdata(lport.wdata),
		.raddr(lport.raddr),
		.rdata(l_rdata)
	);

endmodule

// ===== bench/linked_list_reorder_engine_checker.sv =====
// checker for the linked-list reorder engine: tracks the list from accepted requests
// and compares each odd-position sum on m_axis with its prediction
// depends on llre_pkg
`timescale 1ns / 1ps

module linked_list_reorder_engine_checker import llre_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[2:0], item_x[13:3], item_y[24:14]
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // odd_position_sum[19:0]
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data,
	output int                     pending,
	output int                     errors
);

	logic [IDX_W-1:0] next_of [0:MAX_ITEMS];
	logic [IDX_W-1:0] prev_of [0:MAX_ITEMS];
	logic             flipped;
	int               live_count;
	logic [LEN_W-1:0] length_reg;
	logic [SUM_W-1:0] sums_due [$];
	logic [SUM_W-1:0] expected_sum;
	int               result_no;

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		errors++;
		$display("mismatch at result %0d: %s expected %0d got %0d", result_no, what, want, got);
	endtask

	function automatic logic [SUM_W-1:0] odd_sum();
		int node;
		int total;
		node = 0;
		total = 0;
		for (int i = 1; i <= live_count; i++) begin
			node = int'(next_of[node]);
			if (i % 2 == 1)
				total += node;
		end
		// reversed walk of an even-length list picks the other half
		if (flipped && live_count % 2 == 0)
			total = live_count * (live_count + 1) / 2 - total;
		return total[SUM_W-1:0];
	endfunction

	task automatic relink(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
		next_of[a] = b;
		prev_of[b] = a;
	endtask

	task automatic apply_command(input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] xi,
			input logic [IDX_W-1:0] yi);
		logic [MODE_W-1:0] kind;
		logic [IDX_W-1:0]  x, y, lx, rx, ly, ry;
		int                len;
		kind = op;
		x = xi;
		y = yi;
		case (op) inside
			MODE_INIT: begin
				len = (length_reg == 0) ? 1 : (length_reg > MAX_ITEMS) ? MAX_ITEMS : length_reg;
				for (int i = 0; i <= len; i++) begin
					next_of[i] = (i == len) ? '0 : IDX_W'(i + 1);
					prev_of[i] = (i == 0) ? IDX_W'(len) : IDX_W'(i - 1);
				end
				live_count = len;
				flipped = 1'b0;
			end
			MODE_REV: flipped = !flipped;
			MODE_REPORT: sums_due = {sums_due, odd_sum()};
			MODE_MOVE_L, MODE_MOVE_R, MODE_SWAP: begin
				if (x != y && x >= 1 && y >= 1 && x <= live_count && y <= live_count) begin
					// left and right trade places while the list is reversed
					if (op != MODE_SWAP && flipped)
						kind = (op == MODE_MOVE_L) ? MODE_MOVE_R : MODE_MOVE_L;
					if (kind == MODE_MOVE_L) begin
						if (prev_of[y] != x) begin
							lx = prev_of[x];
							rx = next_of[x];
							relink(lx, rx);
							ly = prev_of[y];
							relink(ly, x);
							relink(x, y);
						end
					end else if (kind == MODE_MOVE_R) begin
						if (next_of[y] != x) begin
							lx = prev_of[x];
							rx = next_of[x];
							relink(lx, rx);
							ry = next_of[y];
							relink(y, x);
							relink(x, ry);
						end
					end else begin
						if (next_of[y] == x) begin
							x = yi;
							y = xi;
						end
						lx = prev_of[x];
						rx = next_of[x];
						ly = prev_of[y];
						ry = next_of[y];
						if (rx == y) begin
							relink(lx, y);
							relink(y, x);
							relink(x, ry);
						end else begin
							relink(lx, y);
							relink(y, rx);
							relink(ly, x);
							relink(x, ry);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flipped = 1'b0;
			live_count = 0;
			length_reg = LEN_W'(MAX_ITEMS);
			sums_due.delete();
			errors = 0;
			result_no = 0;
		end else begin
			// results first: a request accepted at this edge cannot have produced one yet
			if (m_axis_tvalid && m_axis_tready) begin
				result_no++;
				if (sums_due.size() == 0) begin
					report_mismatch("result with no report waiting", '0,
						m_axis_tdata[SUM_W-1:0]);
				end else begin
					expected_sum = sums_due.pop_front();
					if (m_axis_tdata[SUM_W-1:0] != expected_sum)
						report_mismatch("odd_position_sum", expected_sum,
							m_axis_tdata[SUM_W-1:0]);
				end
			end
			if (cfg_valid && cfg_ready)
				length_reg = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				apply_command(s_axis_tdata[MODE_W-1:0], s_axis_tdata[MODE_W +: IDX_W],
					s_axis_tdata[MODE_W + IDX_W +: IDX_W]);
		end
		pending = sums_due.size();
	end

endmodule

// ===== bench/linked_list_reorder_engine_top_tb.sv =====
// testbench top for the linked-list reorder engine: drives command requests, list
// lengths and result back-pressure, runs the watchdog and gives the verdict
// depends on llre_pkg, linked_list_reorder_engine_top, linked_list_reorder_engine_checker
`timescale 1ns / 1ps

module linked_list_reorder_engine_top_tb import llre_pkg::*; ();

	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1100;
	localparam int PHASES       = 11;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // mode[2:0], item_x[13:3], item_y[24:14]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // odd_position_sum[19:0]
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [LEN_W-1:0]       cfg_data;

	int pending;
	int errors;
	int quiet_cycles;
	bit calm;
	int list_n;

	// lengths beyond 1..1024 check the saturation on init
	int phase_len   [0:PHASES-1] = '{0, 2, 3, 2047, 8, 1, 16, 29, 64, 1024, 12};
	int phase_items [0:PHASES-1] = '{40, 60, 60, 15, 80, 30, 120, 90, 90, 15, 100};

	linked_list_reorder_engine_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	linked_list_reorder_engine_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.errors        (errors)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_command(input logic [MODE_W-1:0] op, input logic [IDX_W-1:0] x,
			input logic [IDX_W-1:0] y);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {{(IN_TDATA_W - MODE_W - 2 * IDX_W){1'b0}}, y, x, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// moves leave no result behind, so give the engine its longest walk before writing
	task automatic write_length(input logic [LEN_W-1:0] v);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		list_n = (v == 0) ? 1 : (v > MAX_ITEMS) ? MAX_ITEMS : v;
	endtask

	task automatic send_random(input int count);
		int                r;
		logic [MODE_W-1:0] op;
		logic [IDX_W-1:0]  x, y;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			x = IDX_W'($urandom_range(list_n, 1));
			y = IDX_W'($urandom_range(list_n, 1));
			op = MODE_W'($urandom_range(MODE_SWAP, MODE_MOVE_L));
			if (r < 10) begin
				op = MODE_W'($urandom_range((1 << MODE_W) - 1));
				x = IDX_W'($urandom_range((1 << IDX_W) - 1));
				y = IDX_W'($urandom_range((1 << IDX_W) - 1));
			end else if (r < 22) begin
				op = MODE_REPORT;
			end else if (r < 30) begin
				op = MODE_REV;
			end else if (r < 32) begin
				op = MODE_INIT;
			end
			if ($urandom_range(99) < 3)
				wait_drained();
			send_command(op, x, y);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		list_n = MAX_ITEMS;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list after reset, then the full default length
		send_command(MODE_REPORT, 11'd1, 11'd2);
		send_command(MODE_MOVE_L, 11'd1, 11'd2);
		send_command(MODE_SWAP, 11'd1, 11'd2);
		send_command(MODE_INIT, 11'd2047, 11'd2047);
		send_command(MODE_REPORT, 11'd0, 11'd0);
		send_command(MODE_MOVE_L, 11'd1024, 11'd1);
		send_command(MODE_MOVE_R, 11'd1, 11'd1024);
		send_command(MODE_SWAP, 11'd1, 11'd1024);
		send_command(MODE_REV, 11'd0, 11'd0);
		send_command(MODE_REPORT, 11'd0, 11'd0);
		send_command(MODE_REV, 11'd0, 11'd0);

		// short odd list: ignored cases, moves already in place, both swap shapes
		write_length(11'd5);
		send_command(MODE_INIT, 11'd0, 11'd0);
		send_command(MODE_MOVE_L, 11'd3, 11'd3);
		send_command(MODE_MOVE_L, 11'd0, 11'd2);
		send_command(MODE_MOVE_R, 11'd2, 11'd6);
		send_command(MODE_SWAP, 11'd2047, 11'd1);
		send_command(MODE_MOVE_L, 11'd1, 11'd2);
		send_command(MODE_MOVE_R, 11'd2, 11'd1);
		send_command(MODE_SWAP, 11'd3, 11'd2);
		send_command(MODE_SWAP, 11'd2, 11'd3);
		send_command(MODE_SWAP, 11'd1, 11'd5);
		send_command(MODE_REV, 11'd0, 11'd0);
		send_command(MODE_MOVE_L, 11'd4, 11'd1);
		send_command(MODE_REPORT, 11'd0, 11'd0);
		send_command(MODE_SPARE_LO, 11'd1, 11'd2);
		send_command(MODE_SPARE_HI, 11'd2, 11'd1);
		send_command(MODE_REPORT, 11'd0, 11'd0);

		for (int p = 0; p < PHASES; p++) begin
			calm = (p == 6);
			write_length(LEN_W'(phase_len[p]));
			send_command(MODE_INIT, 11'd0, 11'd0);
			send_random(phase_items[p]);
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/llre_pkg.sv
rtl/llre_link_ram.sv
rtl/llre_seq.sv
rtl/linked_list_reorder_engine_top.sv
bench/linked_list_reorder_engine_checker.sv
bench/linked_list_reorder_engine_top_tb.sv
